/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the double-ended queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* rtl/dq_pkg.sv */
// Package with the types and constants of the double-ended queue.
package dq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int OP_W          = 3;
    localparam int TAG_W         = 16;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int LEN_W         = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK       = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/double_ended_queue.sv */
// Top level of the double-ended queue: ring buffer control, entry RAM and result path.
//
//   Channel   | Handshake                    | Beat contents
//   ----------+------------------------------+-----------------------------------------
//   command   | start in, busy out           | operation, item_tag, item_value
//   result    | done out (one-cycle strobe)  | status, front_tag, front_value,
//             |                              | back_tag, back_value, length, is_empty
//
// A command beat is taken at every clock edge where start is high; busy stays low,
// so one beat per cycle is sustained.
// The result of a beat appears in the cycle after it is taken, marked by done.
// That delay is the registered read of the entry RAM.
// Reset clears the head index and the entry count; the entry RAM is not cleared,
// since only slots that hold entries are ever shown.
// The result side has no stall: done is a strobe, and the receiver must take it.
`include "assert_macros.svh"

module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OP_W-1:0]            operation,
    input  logic [TAG_W-1:0]           item_tag,
    input  logic signed [VALUE_W-1:0]  item_value,
    output logic                       done,
    output logic [STATUS_W-1:0]        status,
    output logic [TAG_W-1:0]           front_tag,
    output logic signed [VALUE_W-1:0]  front_value,
    output logic [TAG_W-1:0]           back_tag,
    output logic signed [VALUE_W-1:0]  back_value,
    output logic [LEN_W-1:0]           length,
    output logic                       is_empty
);

    // Slot index width, count width (the count can reach DEPTH itself), and a
    // sum width wide enough for a slot index plus a count.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_SUM = SW'(DEPTH);

    // Control state of the ring.
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          done_reg;

    // Result registers that sit beside the RAM read registers.
    status_t          status_reg, status_next;
    logic [LEN_W-1:0] length_reg;
    logic             empty_reg;
    logic             fwd_front_reg, fwd_back_reg;
    entry_t           push_data_reg;

    logic          accept;
    logic          is_full, is_none;
    logic [AW-1:0] head_inc, head_dec, tail_slot, back_slot;
    logic [SW-1:0] tail_sum, back_sum;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic [ENTRY_W-1:0] rd_front_raw, rd_back_raw;
    entry_t        rd_front, rd_back, front_entry, back_entry;

    // The queue never needs to hold a command off.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign is_full = (count_reg == FULL_CNT);
    assign is_none = (count_reg == '0);

    // Neighbors of the head slot, wrapping around the ring.
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);

    // The free slot just past the back entry.
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_slot = (tail_sum >= DEPTH_SUM) ? AW'(tail_sum - DEPTH_SUM) : AW'(tail_sum);

    assign wr_data.tag   = item_tag;
    assign wr_data.value = item_value;

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = ST_DONE;
        wr_en       = 1'b0;
        wr_addr     = tail_slot;
        if (accept)
        begin
            case (op_t'(operation))
                OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        head_next  = head_dec;
                        count_next = count_reg + CW'(1);
                        wr_en      = 1'b1;
                        wr_addr    = head_dec;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                        wr_en      = 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (is_none)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                OP_POP_BACK:
                begin
                    if (is_none)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    // Peek and unused codes leave the queue as it is.
                end
            endcase
        end
    end

    // Back slot after the operation; only meaningful when the queue is not empty.
    assign back_sum  = SW'(head_next) + SW'(count_next) - SW'(1);
    assign back_slot = (back_sum >= DEPTH_SUM) ? AW'(back_sum - DEPTH_SUM) : AW'(back_sum);

    dq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .raddr_a (head_next),
        .raddr_b (back_slot),
        .rdata_a (rd_front_raw),
        .rdata_b (rd_back_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // The RAM returns old data when a slot is read in the cycle it is written,
    // so a freshly pushed entry is forwarded from its own register instead.
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        length_reg    <= LEN_W'(count_next);
        empty_reg     <= (count_next == '0);
        fwd_front_reg <= wr_en && (wr_addr == head_next);
        fwd_back_reg  <= wr_en && (wr_addr == back_slot);
        push_data_reg <= wr_data;
    end

    assign rd_front = entry_t'(rd_front_raw);
    assign rd_back  = entry_t'(rd_back_raw);

    // An empty queue shows zero at both ends.
    always_comb
    begin
        if (empty_reg)
        begin
            front_entry = '0;
            back_entry  = '0;
        end
        else
        begin
            front_entry = fwd_front_reg ? push_data_reg : rd_front;
            back_entry  = fwd_back_reg ? push_data_reg : rd_back;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign front_tag   = front_entry.tag;
    assign front_value = front_entry.value;
    assign back_tag    = back_entry.tag;
    assign back_value  = back_entry.value;
    assign length      = length_reg;
    assign is_empty    = empty_reg;

    // Every taken command beat yields a result beat in the next cycle, and no other.
    `ASSERT_CLK(a_result_follows, clk, rst_n, accept |=> done, "result beat missing after a command")
    `ASSERT_CLK(a_result_has_cmd, clk, rst_n, done |-> $past(accept), "result beat without a command")
    // The ring never holds more than DEPTH entries and the head stays inside the ring.
    `ASSERT_NEVER(a_count_range, clk, rst_n, (count_reg > FULL_CNT) || (head_reg > LAST_SLOT), "ring state out of range")
    // A full status is only reported when the queue was full at the command.
    `ASSERT_CLK(a_full_status, clk, rst_n, (done && (status == ST_FULL)) |-> $past(is_full), "full status on a queue that was not full")
    // An empty queue shows zero entries at both ends.
    `ASSERT_CLK(a_empty_zero, clk, rst_n, (done && is_empty) |-> ((front_entry == '0) && (back_entry == '0)), "empty queue shows a nonzero entry")

endmodule

/* rtl/dq_ram.sv */
// Generic RAM with one write port and two registered read ports.
module dq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* test/double_ended_queue_test.sv */
// Self-checking testbench for the double-ended queue: a directed table, then random traffic.
module double_ended_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    // The block is built with its default depth.
    localparam int DQ_DEPTH = DEPTH_DEFAULT;

    // Sender gaps are drawn per beat from 0 to this many cycles.
    localparam int IDLE_MAX = 11;

    // Idling is switched on or off, and the traffic mix redrawn, every this many beats.
    localparam int MODE_SPAN = 32;

    // The directed table holds 25 beats; the random part brings the total near 1850.
    localparam int RANDOM_BEATS = 1825;

    // Cycles without any beat in either direction before the run is declared hung.
    // The longest correct quiet stretch is one sender gap plus the result latency.
    localparam int STALL_LIMIT = 400;

    // The result comes in the cycle after its command, so this wait covers the tail.
    localparam int DRAIN_CYCLES = 4;

    // Operation codes above the peek code are not defined; the block treats them as peek.
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;

    localparam logic [TAG_W-1:0] TAG_MAX = '1;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Random traffic runs in stretches that lean toward filling, draining, or neither,
    // so that the queue keeps hitting both its empty and its full state.
    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } traffic_mode_t;

    // One result beat, as the block shows it.
    typedef struct packed {
        status_t                   status;
        logic [TAG_W-1:0]          front_tag;
        logic signed [VALUE_W-1:0] front_value;
        logic [TAG_W-1:0]          back_tag;
        logic signed [VALUE_W-1:0] back_value;
        logic [LEN_W-1:0]          length;
        logic                      is_empty;
    } outcome_t;

    // One row of the directed table. Rows marked typed carry a hand-written result;
    // the others are checked against the predicted one.
    typedef struct {
        logic [OP_W-1:0]           op;
        logic [TAG_W-1:0]          tag;
        logic signed [VALUE_W-1:0] value;
        bit                        typed;
        outcome_t                  want;
    } plan_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [OP_W-1:0]           operation = OP_PEEK;
    logic [TAG_W-1:0]          item_tag = '0;
    logic signed [VALUE_W-1:0] item_value = '0;
    logic                      done;
    logic [STATUS_W-1:0]       status;
    logic [TAG_W-1:0]          front_tag;
    logic signed [VALUE_W-1:0] front_value;
    logic [TAG_W-1:0]          back_tag;
    logic signed [VALUE_W-1:0] back_value;
    logic [LEN_W-1:0]          length;
    logic                      is_empty;

    // Shadow copy of the ring buffer: slots, head slot and entry count.
    entry_t shadow_slots [DQ_DEPTH];
    int     shadow_head = 0;
    int     shadow_count = 0;

    // Results that are owed by the block, oldest first.
    outcome_t  pending_outcomes[$];
    plan_row_t directed_plan[$];

    int mismatch_count = 0;
    int beats_sent = 0;
    bit idling_on = 1'b1;

    double_ended_queue u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .item_tag    (item_tag),
        .item_value  (item_value),
        .done        (done),
        .status      (status),
        .front_tag   (front_tag),
        .front_value (front_value),
        .back_tag    (back_tag),
        .back_value  (back_value),
        .length      (length),
        .is_empty    (is_empty)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Applies one command to the shadow queue and returns the result it must produce.
    // A push at the front moves the head back one slot and writes there; a push at the
    // back writes just past the last entry. A pop at the front moves the head forward;
    // a pop at the back only shrinks the count. Pops on an empty queue and pushes on a
    // full one leave everything as it was and only report it. Any other code is a peek.
    function automatic outcome_t apply_operation(input logic [OP_W-1:0] op,
                                                 input logic [TAG_W-1:0] tag,
                                                 input logic signed [VALUE_W-1:0] value);
        outcome_t res;
        int       slot;
        int       tail;
        res = '0;
        res.status = ST_DONE;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
        begin
            if (shadow_count >= DQ_DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                if (op == OP_PUSH_FRONT)
                begin
                    shadow_head = (shadow_head + DQ_DEPTH - 1) % DQ_DEPTH;
                    slot = shadow_head;
                end
                else
                begin
                    slot = (shadow_head + shadow_count) % DQ_DEPTH;
                end
                shadow_slots[slot].tag = tag;
                shadow_slots[slot].value = value;
                shadow_count++;
            end
        end
        else if (op == OP_POP_FRONT || op == OP_POP_BACK)
        begin
            if (shadow_count == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                if (op == OP_POP_FRONT)
                    shadow_head = (shadow_head + 1) % DQ_DEPTH;
                shadow_count--;
            end
        end
        // An empty queue shows zeros at both ends; otherwise only held slots are read.
        if (shadow_count != 0)
        begin
            tail = (shadow_head + shadow_count - 1) % DQ_DEPTH;
            res.front_tag = shadow_slots[shadow_head].tag;
            res.front_value = shadow_slots[shadow_head].value;
            res.back_tag = shadow_slots[tail].tag;
            res.back_value = shadow_slots[tail].value;
        end
        res.length = shadow_count[LEN_W-1:0];
        res.is_empty = (shadow_count == 0);
        return res;
    endfunction

    // Builds a hand-written result; the queue is empty exactly when the length is zero.
    function automatic outcome_t make_outcome(input status_t st,
                                              input logic [TAG_W-1:0] ftag,
                                              input logic signed [VALUE_W-1:0] fval,
                                              input logic [TAG_W-1:0] btag,
                                              input logic signed [VALUE_W-1:0] bval,
                                              input logic [LEN_W-1:0] len);
        outcome_t res;
        res.status = st;
        res.front_tag = ftag;
        res.front_value = fval;
        res.back_tag = btag;
        res.back_value = bval;
        res.length = len;
        res.is_empty = (len == 0);
        return res;
    endfunction

    function automatic void add_row(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag,
                                    input logic signed [VALUE_W-1:0] value, input bit typed,
                                    input outcome_t want);
        plan_row_t row;
        row.op = op;
        row.tag = tag;
        row.value = value;
        row.typed = typed;
        row.want = want;
        directed_plan.push_back(row);
    endfunction

    // The directed table. It starts on the empty queue left by reset, pushes and pops
    // the field extremes, empties the queue again from both ends, then fills it from
    // both ends (the first push at the front wraps the head below slot zero) and ends
    // with a push on the full queue.
    function automatic void load_directed_plan();
        outcome_t empty_done;
        outcome_t empty_pop;
        int       k;
        empty_done = make_outcome(ST_DONE, '0, '0, '0, '0, '0);
        empty_pop = make_outcome(ST_EMPTY, '0, '0, '0, '0, '0);
        add_row(OP_POP_FRONT, TAG_MAX, VALUE_MAX, 1'b1, empty_pop);
        add_row(OP_POP_BACK, '0, VALUE_MIN, 1'b1, empty_pop);
        add_row(OP_PEEK, TAG_MAX, '1, 1'b1, empty_done);
        add_row(OP_SPARE_HI, TAG_MAX, '1, 1'b1, empty_done);
        add_row(OP_PUSH_BACK, TAG_MAX, VALUE_MAX, 1'b1,
                make_outcome(ST_DONE, TAG_MAX, VALUE_MAX, TAG_MAX, VALUE_MAX, 5'd1));
        add_row(OP_PUSH_FRONT, '0, VALUE_MIN, 1'b1,
                make_outcome(ST_DONE, '0, VALUE_MIN, TAG_MAX, VALUE_MAX, 5'd2));
        add_row(OP_POP_BACK, '0, '0, 1'b1,
                make_outcome(ST_DONE, '0, VALUE_MIN, '0, VALUE_MIN, 5'd1));
        // Popping the last entry leaves the queue fully empty.
        add_row(OP_POP_FRONT, '0, '0, 1'b1, empty_done);
        for (k = 0; k < DQ_DEPTH - 2; k++)
        begin
            add_row((k % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, TAG_W'(16'h1000 + k),
                    -32'sd7 * k + 32'sd3, 1'b0, '0);
        end
        add_row(OP_PUSH_FRONT, 16'h5A5A, -32'sd1, 1'b0, '0);
        add_row(OP_PUSH_BACK, 16'hA5A5, 32'sh1234_5678, 1'b0, '0);
        add_row(OP_PUSH_FRONT, 16'h0F0F, 32'sd7, 1'b1,
                make_outcome(ST_FULL, 16'h5A5A, -32'sd1, 16'hA5A5, 32'sh1234_5678, 5'd16));
    endfunction

    // Drives one command beat. The gap before it is drawn per beat; start stays high
    // from one beat to the next when there is no gap, so it is never dropped and raised
    // in the same time step. The beat is taken at the first edge that sees busy low,
    // and the shadow queue moves at that same edge.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag,
                             input logic signed [VALUE_W-1:0] value, input bit typed,
                             input outcome_t typed_want);
        int       gap;
        outcome_t predicted;
        if (beats_sent % MODE_SPAN == 0)
            idling_on = ($urandom_range(2) != 0);
        gap = idling_on ? $urandom_range(IDLE_MAX) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        item_tag <= tag;
        item_value <= value;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        predicted = apply_operation(op, tag, value);
        pending_outcomes.push_back(typed ? typed_want : predicted);
        beats_sent++;
    endtask

    function automatic void compare_field(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    // Checks the result beat on the ports against the oldest owed result.
    function automatic void check_result();
        outcome_t want;
        if (pending_outcomes.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: result beat with nothing expected", $time);
            return;
        end
        want = pending_outcomes.pop_front();
        compare_field("status", 64'(want.status), 64'(status));
        compare_field("front_tag", 64'(want.front_tag), 64'(front_tag));
        compare_field("front_value", 64'(want.front_value), 64'(front_value));
        compare_field("back_tag", 64'(want.back_tag), 64'(back_tag));
        compare_field("back_value", 64'(want.back_value), 64'(back_value));
        compare_field("length", 64'(want.length), 64'(length));
        compare_field("is_empty", 64'(want.is_empty), 64'(is_empty));
    endfunction

    // Result monitor. Outputs are read at the rising edge, before that edge's updates
    // land, so each beat is seen in the one cycle that done marks it.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && done !== 1'b0)
                check_result();
        end
    end

    // Watchdog: any cycle with a beat in either direction restarts the count.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Main sequence: reset, the directed table, then random traffic.
    initial
    begin
        traffic_mode_t             mode;
        int                        push_pct;
        int                        n;
        logic [OP_W-1:0]           op;
        logic [TAG_W-1:0]          tag;
        logic signed [VALUE_W-1:0] value;
        mode = MODE_MIXED;
        push_pct = 50;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_directed_plan();
        foreach (directed_plan[i])
            send_beat(directed_plan[i].op, directed_plan[i].tag, directed_plan[i].value,
                      directed_plan[i].typed, directed_plan[i].want);

        // Random traffic. Most beats push or pop, leaning the way the current stretch
        // says; a few are peeks or undefined codes. Fields of pops and peeks are still
        // random, since the block must ignore them. Extremes of tag and value are mixed in.
        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % MODE_SPAN == 0)
            begin
                mode = traffic_mode_t'($urandom_range(2));
                push_pct = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 20 : 50;
            end
            if ($urandom_range(99) < 8)
                op = OP_W'($urandom_range(OP_SPARE_HI, OP_PEEK));
            else if ($urandom_range(99) < push_pct)
                op = ($urandom_range(1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
                op = ($urandom_range(1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
            tag = TAG_W'($urandom);
            if ($urandom_range(7) == 0)
                tag = ($urandom_range(1) != 0) ? TAG_MAX : '0;
            value = $urandom;
            case ($urandom_range(15))
                0: value = VALUE_MAX;
                1: value = VALUE_MIN;
                2: value = '0;
                3: value = '1;
                default: ;
            endcase
            send_beat(op, tag, value, 1'b0, '0);
        end
        start <= 1'b0;

        // Wait for every owed result, then a few cycles to catch a stray beat.
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // The spare low code only serves this check that it follows peek; the random part's range starts at peek.
    initial
    begin
        if (OP_SPARE_LO != OP_PEEK + 1)
            $display("%0t: spare operation codes do not follow peek", $time);
    end

endmodule

/* files.f */
+incdir+rtl
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/double_ended_queue.sv
test/double_ended_queue_test.sv
